### rtl/rsr_pkg.sv
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types and codes of the stereo resampler: item kinds, register
// indexes, output sample formats and the datapath stage strobes.
// ----------------------------------------------------------------------------
package rsr_pkg;

    // item kinds carried in s_tuser
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_PULL  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_RATE_STEP  = 2'd0;
    localparam logic [1:0] REG_SAMPLE_FMT = 2'd1;
    localparam logic [1:0] REG_MAX_FRAMES = 2'd2;

    // output sample formats
    typedef logic [2:0] rsr_fmt_t;
    localparam rsr_fmt_t FMT_INT16 = 3'd0;
    localparam rsr_fmt_t FMT_INT24 = 3'd1;
    localparam rsr_fmt_t FMT_INT32 = 3'd2;
    localparam rsr_fmt_t FMT_LJ16  = 3'd3;
    localparam rsr_fmt_t FMT_LJ18  = 3'd4;
    localparam rsr_fmt_t FMT_LJ20  = 3'd5;
    localparam rsr_fmt_t FMT_LJ24  = 3'd6;

    // strobes that move one channel through the interpolation datapath
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic scl_en;
        logic rnd_en;
    } rsr_stage_t;

endpackage

### rtl/rsr_mem.sv
// ----------------------------------------------------------------------------
// rsr_mem
// Frame store: one write port and two registered read ports, so that the
// two oldest frames come out together in the cycle after the read.
// ----------------------------------------------------------------------------
module rsr_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [31:0]   rd_data_a,
    output logic [31:0]   rd_data_b
);

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read ports, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### rtl/rsr_fmt.sv
// ----------------------------------------------------------------------------
// rsr_fmt
// One channel of interpolation and packing: difference times fraction,
// accumulate onto the older sample, scale to the output range, round half
// away from zero and pack into the selected format.
// ----------------------------------------------------------------------------
module rsr_fmt
    import rsr_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  logic                 aclk,
    input  rsr_stage_t           stage,
    input  rsr_fmt_t             fmt,
    input  logic signed [15:0]   s0,
    input  logic signed [15:0]   s1,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [31:0]          word
);

    localparam int VW = FRAC_BITS + 18;
    localparam int XW = VW + 31;
    localparam int DS = FRAC_BITS + 15;

    logic signed [16:0]        diff;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [VW-1:0]      prod_next;
    logic signed [VW-1:0]      prod_reg;
    logic signed [15:0]        base_reg;
    logic signed [VW-1:0]      acc;
    logic [VW-1:0]             mag_next;
    logic [VW-1:0]             mag_reg;
    logic                      neg_reg;
    logic [4:0]                k;
    logic [XW-1:0]             x_next;
    logic [XW-1:0]             x_reg;
    logic [XW-1:0]             t;
    logic [31:0]               q;
    logic [31:0]               sv;
    logic [31:0]               word_next;
    logic [31:0]               word_reg;

    // slope times phase fraction
    assign diff      = {s1[15], s1} - {s0[15], s0};
    assign frac_s    = {1'b0, frac};
    assign prod_next = VW'(diff) * VW'(frac_s);

    // value on the source grid and its magnitude
    assign acc      = (VW'(base_reg) <<< FRAC_BITS) + prod_reg;
    assign mag_next = acc[VW-1] ? VW'(-acc) : VW'(acc);

    // full-scale exponent of the format
    always_comb begin
        case (fmt)
            FMT_INT16: k = 5'd15;
            FMT_INT24: k = 5'd23;
            FMT_INT32: k = 5'd31;
            FMT_LJ16:  k = 5'd15;
            FMT_LJ18:  k = 5'd17;
            FMT_LJ20:  k = 5'd19;
            FMT_LJ24:  k = 5'd23;
            default:   k = 5'd15;
        endcase
    end

    // magnitude times (2^k - 1)
    assign x_next = (XW'(mag_reg) << k) - XW'(mag_reg);

    // round half up on the magnitude, then restore the sign
    assign t  = x_reg + (XW'(1) << (DS - 1));
    assign q  = t[DS+31:DS];
    assign sv = neg_reg ? (32'd0 - q) : q;

    // packing
    always_comb begin
        case (fmt)
            FMT_INT16: word_next = {16'd0, sv[15:0]};
            FMT_INT24: word_next = {8'd0, sv[23:0]};
            FMT_INT32: word_next = sv;
            FMT_LJ16:  word_next = {sv[15:0], 16'd0};
            FMT_LJ18:  word_next = {sv[17:0], 14'd0};
            FMT_LJ20:  word_next = {sv[19:0], 12'd0};
            FMT_LJ24:  word_next = {sv[23:0], 8'd0};
            default:   word_next = 32'd0;
        endcase
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (stage.mul_en) begin
            prod_reg <= prod_next;
            base_reg <= s0;
        end
        if (stage.acc_en) begin
            mag_reg <= mag_next;
            neg_reg <= acc[VW-1];
        end
        if (stage.scl_en) begin
            x_reg <= x_next;
        end
        if (stage.rnd_en) begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

### rtl/stereo_fifo_linear_resampler.sv
// ----------------------------------------------------------------------------
// stereo_fifo_linear_resampler
// Frame FIFO with a linear interpolating read side for stereo 16-bit audio.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_       | s_tvalid/s_tready  | tuser kind, tdata left_in, right_in
//  m_       | m_tvalid/m_tready  | tdata left/right word, fill; tuser flags
//  cfg_     | cfg_wr_en          | cfg_index, cfg_wdata
//
// Push, clear and no-op load the result register after the execute state,
// as does a pull that underruns; a pull with two or more frames queued
// first passes store read, multiply, accumulate, scale and round. Items
// are taken one at a time. A new result waits in the final state while the
// previous beat is untaken, then the next item is accepted in idle. Reset
// is synchronous and needs no clearing pass over the frame store.
// ----------------------------------------------------------------------------
module stereo_fifo_linear_resampler
    import rsr_pkg::*;
#(
    parameter int FIFO_DEPTH      = 32768,
    parameter int PHASE_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_in [15:0], right_in [31:16]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // left_word [31:0], right_word [63:32], fill_frames [79:64]
    output logic [1:0]  m_tuser,   // underrun [0], overflow [1]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int P    = PHASE_FRAC_BITS;
    localparam int AW   = $clog2(FIFO_DEPTH);
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam int CAPW = (CW > 16) ? CW : 16;
    localparam int NW   = (CW > 4) ? CW : 4;
    localparam int SW   = P + 2;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(FIFO_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EXEC = 7'b0000010,
        ST_RD   = 7'b0000100,
        ST_ACC  = 7'b0001000,
        ST_SCL  = 7'b0010000,
        ST_RND  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      kind_reg;
    logic [31:0]     frame_reg;
    logic [AW-1:0]   rp_reg, rp_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [P+2:0]    phase_reg, phase_next;
    logic [31:0]     rate_step_reg;
    rsr_fmt_t        fmt_reg;
    logic [15:0]     max_frames_reg;
    logic            und_reg, und_next;
    logic            ovf_reg, ovf_next;
    logic            pull_ok_reg, pull_ok_next;
    logic            m_tvalid_reg;
    logic [79:0]     m_tdata_reg;
    logic [1:0]      m_tuser_reg;

    logic            out_free;
    logic [CAPW-1:0] max_ext, cap_w;
    logic [CW-1:0]   cap;
    logic [CW-1:0]   drop;
    logic [CW-1:0]   cnt_base;
    logic [SW-1:0]   step;
    logic [P+3:0]    sum;
    logic [3:0]      ip;
    logic [NW-1:0]   ip_w, cm_w, n_w;
    logic [3:0]      ip_rem;
    logic            mem_we, mem_re;
    logic [AW-1:0]   rd_addr_b;
    logic [31:0]     rd_data_a, rd_data_b;
    rsr_stage_t      stage;
    logic [31:0]     left_word, right_word;
    logic [AW:0]     ptr_diff;

    // pointer advance modulo the store depth
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [AW-1:0] n);
        logic [AW:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    // phase step rescaled from Q2.30
    generate
        if (P >= 30) begin : g_step_up
            assign step = SW'(rate_step_reg) << (P - 30);
        end else begin : g_step_dn
            assign step = SW'(rate_step_reg >> (30 - P));
        end
    endgenerate

    // effective cap, limited to [2, depth]
    always_comb begin
        max_ext = CAPW'(max_frames_reg);
        if (max_ext < CAPW'(2)) begin
            cap_w = CAPW'(2);
        end else if (max_ext > CAPW'(FIFO_DEPTH)) begin
            cap_w = CAPW'(FIFO_DEPTH);
        end else begin
            cap_w = max_ext;
        end
    end
    assign cap      = cap_w[CW-1:0];
    assign drop     = count_reg - cap + CW'(1);
    assign cnt_base = (count_reg >= cap) ? (cap - CW'(1)) : count_reg;

    // phase advance and pops for a pull
    assign sum    = {1'b0, phase_reg} + (P + 4)'(step);
    assign ip     = sum[P+3:P];
    assign ip_w   = NW'(ip);
    assign cm_w   = NW'(count_reg - CW'(1));
    assign n_w    = (ip_w > cm_w) ? cm_w : ip_w;
    assign ip_rem = ip - n_w[3:0];

    // store access: written by a push, read by a pull, never in one cycle
    assign mem_we    = (state_reg == ST_EXEC) && (kind_reg == KIND_PUSH);
    assign mem_re    = (state_reg == ST_EXEC) && (kind_reg == KIND_PULL)
                       && (count_reg >= CW'(2));
    assign rd_addr_b = ptr_add(rp_reg, AW'(1));

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer and queue state
    always_comb begin
        state_next   = state_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        und_next     = und_reg;
        ovf_next     = ovf_reg;
        pull_ok_next = pull_ok_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                und_next     = 1'b0;
                ovf_next     = 1'b0;
                pull_ok_next = 1'b0;
                state_next   = ST_FIN;
                case (kind_reg)
                    KIND_PUSH: begin
                        if (count_reg >= cap) begin
                            rp_next  = ptr_add(rp_reg, drop[AW-1:0]);
                            ovf_next = 1'b1;
                        end
                        wp_next    = ptr_add(wp_reg, AW'(1));
                        count_next = cnt_base + CW'(1);
                    end
                    KIND_PULL: begin
                        if (count_reg >= CW'(2)) begin
                            pull_ok_next = 1'b1;
                            state_next   = ST_RD;
                        end else begin
                            und_next = 1'b1;
                        end
                    end
                    KIND_CLEAR: begin
                        rp_next    = '0;
                        wp_next    = '0;
                        count_next = '0;
                        phase_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RD: begin
                rp_next    = ptr_add(rp_reg, n_w[AW-1:0]);
                count_next = count_reg - n_w[CW-1:0];
                phase_next = {(ip_rem > 4'd7) ? 3'd7 : ip_rem[2:0], sum[P-1:0]};
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_SCL;
            end
            ST_SCL: begin
                state_next = ST_RND;
            end
            ST_RND: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            count_reg      <= '0;
            phase_reg      <= '0;
            und_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            pull_ok_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            rate_step_reg  <= 32'h4000_0000;
            fmt_reg        <= FMT_INT16;
            max_frames_reg <= 16'h8000;
        end else begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            und_reg     <= und_next;
            ovf_reg     <= ovf_next;
            pull_ok_reg <= pull_ok_next;
            if ((state_reg == ST_FIN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RATE_STEP:  rate_step_reg  <= cfg_wdata;
                    REG_SAMPLE_FMT: fmt_reg        <= cfg_wdata[2:0];
                    REG_MAX_FRAMES: max_frames_reg <= cfg_wdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // item capture and result beat payload
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_tvalid) begin
            kind_reg  <= s_tuser;
            frame_reg <= s_tdata;
        end
        if ((state_reg == ST_FIN) && out_free) begin
            m_tdata_reg <= {16'(count_reg),
                            pull_ok_reg ? right_word : 32'd0,
                            pull_ok_reg ? left_word : 32'd0};
            m_tuser_reg <= {ovf_reg, und_reg};
        end
    end

    assign stage.mul_en = (state_reg == ST_RD);
    assign stage.acc_en = (state_reg == ST_ACC);
    assign stage.scl_en = (state_reg == ST_SCL);
    assign stage.rnd_en = (state_reg == ST_RND);

    rsr_mem #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (mem_we),
        .wr_addr   (wp_reg),
        .wr_data   (frame_reg),
        .rd_en     (mem_re),
        .rd_addr_a (rp_reg),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    rsr_fmt #(
        .FRAC_BITS (P)
    ) u_fmt_left (
        .aclk  (aclk),
        .stage (stage),
        .fmt   (fmt_reg),
        .s0    (rd_data_a[15:0]),
        .s1    (rd_data_b[15:0]),
        .frac  (phase_reg[P-1:0]),
        .word  (left_word)
    );

    rsr_fmt #(
        .FRAC_BITS (P)
    ) u_fmt_right (
        .aclk  (aclk),
        .stage (stage),
        .fmt   (fmt_reg),
        .s0    (rd_data_a[31:16]),
        .s1    (rd_data_b[31:16]),
        .frac  (phase_reg[P-1:0]),
        .word  (right_word)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // distance between the pointers around the ring
    always_comb begin
        ptr_diff = {1'b0, wp_reg} - {1'b0, rp_reg};
        if (wp_reg < rp_reg) begin
            ptr_diff = ptr_diff + DEPTH_W;
        end
    end

    // fill never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("frame count beyond store depth");

    // pointers and fill agree
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CW'(FIFO_DEPTH)) ? (ptr_diff == '0)
                                       : (ptr_diff == (AW + 1)'(count_reg)))
        else $error("pointer distance disagrees with frame count");

    // pops after a pull always leave a frame queued
    a_pull_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |=> (count_reg != '0))
        else $error("pull emptied the queue");

    // an underrun beat carries zero words
    a_under_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[63:0] == 64'd0))
        else $error("underrun beat with non-zero words");

endmodule

### tb/sv/tb_stereo_fifo_linear_resampler.sv
// ----------------------------------------------------------------------------
// tb_stereo_fifo_linear_resampler
// Self-checking bench for the stereo frame FIFO with linear interpolation.
// A behavioural model in the bench tracks the frame queue, the phase and the
// registers, predicts every result beat and compares it field by field. The
// run covers directed corners, randomised push/pull traffic over several
// register settings, a long receiver hold-off and a deep fill cut back by a
// smaller cap.
// ----------------------------------------------------------------------------
module tb_stereo_fifo_linear_resampler;
    import rsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD    = 10;
    localparam int          FIFO_DEPTH    = 32768;
    localparam int          PHASE_FRAC    = 30;
    localparam int          SCALE_BITS    = 15 + PHASE_FRAC;
    localparam longint      PHASE_ONE     = longint'(1) << PHASE_FRAC;
    localparam logic [1:0]  KIND_NOP      = 2'd3;
    localparam int          IDLE_PCT      = 36;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASE_ITEMS   = 72;
    localparam int          FILL_ITEMS    = 40;
    localparam int          MAX_PRINTS    = 40;
    localparam longint      LIMIT_CYCLES  = 3_000_000;

    // one result beat as the block presents it
    typedef struct packed {
        logic [31:0] left_word;
        logic [31:0] right_word;
        logic        underrun;
        logic        overflow;
        logic [15:0] fill;
    } out_frame_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // bench control
    logic        idle_on    = 1'b1;
    logic        hold_req   = 1'b0;
    int          hold_count = 0;
    int          err_count  = 0;
    int          beat_count = 0;
    longint      cycle_count = 0;

    // model state and registers
    logic [31:0] frame_mem [FIFO_DEPTH];
    int unsigned rd_ptr   = 0;
    int unsigned wr_ptr   = 0;
    int unsigned fill_cnt = 0;
    logic [63:0] phase_acc = '0;
    logic [31:0] rate_reg  = 32'h4000_0000;
    rsr_fmt_t    fmt_reg   = FMT_INT16;
    logic [15:0] cap_reg   = 16'h8000;

    out_frame_t  pending_out [$];

    stereo_fifo_linear_resampler #(
        .FIFO_DEPTH      (FIFO_DEPTH),
        .PHASE_FRAC_BITS (PHASE_FRAC)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("stereo_fifo_linear_resampler regression: fail");
            $finish;
        end
    end

    // mismatch reporting, printing capped to keep the log short
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTS)
            $display("mismatch on beat %0d, %s: got %h, expected %h",
                     beat_count, what, got, want);
        err_count++;
    endtask

    // round |v| * (2^k - 1) / 2^SCALE_BITS to nearest, ties away from zero,
    // then pack into the selected word layout
    function automatic logic [31:0] sample_word(input longint v, input rsr_fmt_t fmt);
        int          bits;
        logic [127:0] mag;
        logic [127:0] q;
        longint      s;
        logic [63:0] mask;
        case (fmt)
            FMT_INT16: bits = 16;
            FMT_INT24: bits = 24;
            FMT_INT32: bits = 32;
            FMT_LJ16:  bits = 16;
            FMT_LJ18:  bits = 18;
            FMT_LJ20:  bits = 20;
            FMT_LJ24:  bits = 24;
            default:   return 32'd0;
        endcase
        if (v < 0) mag = -v;
        else       mag = v;
        q = (mag * ((128'd1 << (bits - 1)) - 128'd1) + (128'd1 << (SCALE_BITS - 1)))
            >> SCALE_BITS;
        s = (v < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
        if (fmt == FMT_INT16 || fmt == FMT_INT24 || fmt == FMT_INT32) begin
            mask = (64'd1 << bits) - 64'd1;
            return 32'(64'(s) & mask);
        end
        return 32'(64'(s) << (32 - bits));
    endfunction

    // work out the result of one accepted beat and advance the model
    task automatic resampler_predict(input logic [1:0] kind, input logic [15:0] left_s,
                                     input logic [15:0] right_s);
        out_frame_t  res;
        int unsigned cap;
        int unsigned drop;
        int unsigned n;
        int          l0, l1, r0, r1;
        logic [31:0] f0, f1;
        longint      frac;
        longint      lv, rv;
        logic [63:0] ip;
        res = '0;
        case (kind)
            KIND_PUSH: begin
                cap = cap_reg;
                if (cap < 2) cap = 2;
                if (cap > FIFO_DEPTH) cap = FIFO_DEPTH;
                // at the cap the oldest frames go until cap - 1 remain
                if (fill_cnt >= cap) begin
                    drop = fill_cnt - cap + 1;
                    rd_ptr = (rd_ptr + drop) % FIFO_DEPTH;
                    fill_cnt -= drop;
                    res.overflow = 1'b1;
                end
                frame_mem[wr_ptr] = {right_s, left_s};
                wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                fill_cnt++;
            end
            KIND_PULL: begin
                if (fill_cnt >= 2) begin
                    f0 = frame_mem[rd_ptr];
                    f1 = frame_mem[(rd_ptr + 1) % FIFO_DEPTH];
                    l0 = signed'(f0[15:0]);
                    r0 = signed'(f0[31:16]);
                    l1 = signed'(f1[15:0]);
                    r1 = signed'(f1[31:16]);
                    // only the fraction of the phase interpolates
                    frac = phase_acc[PHASE_FRAC-1:0];
                    lv = longint'(l0) * PHASE_ONE + longint'(l1 - l0) * frac;
                    rv = longint'(r0) * PHASE_ONE + longint'(r1 - r0) * frac;
                    res.left_word  = sample_word(lv, fmt_reg);
                    res.right_word = sample_word(rv, fmt_reg);
                    // advance, pop while phase >= 1 keeping one frame, saturate
                    phase_acc = phase_acc + 64'(rate_reg);
                    ip = phase_acc >> PHASE_FRAC;
                    if (ip > 64'(fill_cnt - 1)) n = fill_cnt - 1;
                    else                        n = ip[31:0];
                    rd_ptr = (rd_ptr + n) % FIFO_DEPTH;
                    fill_cnt -= n;
                    ip = ip - 64'(n);
                    if (ip > 64'd7) ip = 64'd7;
                    phase_acc = (ip << PHASE_FRAC) | 64'(phase_acc[PHASE_FRAC-1:0]);
                end else begin
                    res.underrun = 1'b1;
                end
            end
            KIND_CLEAR: begin
                rd_ptr    = 0;
                wr_ptr    = 0;
                fill_cnt  = 0;
                phase_acc = '0;
            end
            default: begin
                // no-op, only the fill is reported
            end
        endcase
        res.fill = 16'(fill_cnt);
        pending_out = {pending_out, res};
    endtask

    // offer one beat, wait for acceptance; called at a rising edge
    task automatic send_beat(input logic [1:0] kind, input logic [15:0] left_s,
                             input logic [15:0] right_s);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {right_s, left_s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        resampler_predict(kind, left_s, right_s);
    endtask

    // let every outstanding beat come back and the block go idle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, only ever issued after wait_idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_RATE_STEP:  rate_reg = val;
            REG_SAMPLE_FMT: fmt_reg  = val[2:0];
            REG_MAX_FRAMES: cap_reg  = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // full-scale values turn up often
    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h7FFF;
        if (r < 20) return 16'h8000;
        if (r < 25) return 16'h0000;
        return 16'($urandom());
    endfunction

    // receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && hold_count < HOLD_CYCLES) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result checker: each beat against the oldest prediction
    always @(posedge aclk) begin : check_out
        out_frame_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_out.size() == 0) begin
                report_mismatch("beat with nothing expected", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_out[0];
                pending_out.delete(0);
                if (m_tdata[31:0] !== want.left_word)
                    report_mismatch("left_word", m_tdata[31:0], want.left_word);
                if (m_tdata[63:32] !== want.right_word)
                    report_mismatch("right_word", m_tdata[63:32], want.right_word);
                if (m_tdata[79:64] !== want.fill)
                    report_mismatch("fill_frames", 32'(m_tdata[79:64]), 32'(want.fill));
                if (m_tuser[0] !== want.underrun)
                    report_mismatch("underrun", 32'(m_tuser[0]), 32'(want.underrun));
                if (m_tuser[1] !== want.overflow)
                    report_mismatch("overflow", 32'(m_tuser[1]), 32'(want.overflow));
            end
            beat_count++;
        end
    end

    // reset-state flow: empty pull, no-op, two pushes, one pull, clear
    task automatic test_basic_flow();
        send_beat(KIND_PULL, 16'($urandom()), 16'($urandom()));
        send_beat(KIND_NOP, 16'($urandom()), 16'($urandom()));
        send_beat(KIND_PUSH, 16'h7FFF, 16'h8000);
        send_beat(KIND_PUSH, 16'h8000, 16'h7FFF);
        send_beat(KIND_PULL, 16'($urandom()), 16'($urandom()));
        send_beat(KIND_CLEAR, 16'($urandom()), 16'($urandom()));
    endtask

    // full-scale frame read out once per format code, unused code 7 included, zero phase held
    task automatic test_formats();
        wait_idle();
        write_reg(REG_RATE_STEP, 32'h0000_0000);
        send_beat(KIND_PUSH, 16'h7FFF, 16'h8000);
        send_beat(KIND_PUSH, 16'h0001, 16'h8001);
        for (int f = 0; f < 8; f++) begin
            wait_idle();
            write_reg(REG_SAMPLE_FMT, 32'(f));
            send_beat(KIND_PULL, 16'($urandom()), 16'($urandom()));
        end
        wait_idle();
        write_reg(REG_SAMPLE_FMT, 32'(FMT_INT16));
    endtask

    // cap below range behaves as two, third push drops the oldest
    task automatic test_overflow();
        wait_idle();
        write_reg(REG_MAX_FRAMES, 32'd0);
        send_beat(KIND_CLEAR, 16'($urandom()), 16'($urandom()));
        repeat (3) send_beat(KIND_PUSH, pick_sample(), pick_sample());
    endtask

    // largest rate step: integer part of the phase runs into saturation
    task automatic test_phase_saturation();
        wait_idle();
        write_reg(REG_RATE_STEP, 32'hFFFF_FFFF);
        send_beat(KIND_PULL, 16'($urandom()), 16'($urandom()));
        repeat (2) begin
            send_beat(KIND_PUSH, pick_sample(), pick_sample());
            send_beat(KIND_PULL, 16'($urandom()), 16'($urandom()));
        end
    endtask

    // receiver holds off while beats keep being offered
    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_RATE_STEP, 32'h4000_0000);
        write_reg(REG_MAX_FRAMES, 32'd8);
        hold_req <= 1'b1;
        repeat (12) begin
            if ($urandom_range(0, 1) == 0) send_beat(KIND_PUSH, pick_sample(), pick_sample());
            else                           send_beat(KIND_PULL, pick_sample(), pick_sample());
        end
    endtask

    // random traffic over a series of register settings
    task automatic test_random_phases();
        logic [31:0] rate;
        logic [15:0] cap;
        int          fmt_base;
        int          r;
        logic [1:0]  kind;
        fmt_base = $urandom_range(0, 7);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    rate = 32'h4000_0000;
                    cap  = 16'hFFFF;
                end
                1: begin
                    rate = 32'hFFFF_FFFF;
                    cap  = 16'h0000;
                end
                2: begin
                    rate = 32'h0000_0000;
                    cap  = 16'd5;
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) rate = $urandom();
                    else rate = 32'h3C00_0000 + $urandom_range(0, 32'h0800_0000);
                    if ($urandom_range(0, 1) == 0) cap = 16'($urandom_range(2, 40));
                    else                           cap = 16'($urandom());
                end
            endcase
            wait_idle();
            write_reg(REG_RATE_STEP, rate);
            write_reg(REG_SAMPLE_FMT, 32'((ph + fmt_base) % 8));
            write_reg(REG_MAX_FRAMES, 32'(cap));
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                // keep the queue fed when it runs dry, rare clears and no-ops
                if (r < 3)                               kind = KIND_CLEAR;
                else if (r < 6)                          kind = KIND_NOP;
                else if (fill_cnt < 2 && r < 75)         kind = KIND_PUSH;
                else if (r < 53)                         kind = KIND_PUSH;
                else                                     kind = KIND_PULL;
                send_beat(kind, pick_sample(), pick_sample());
            end
        end
    endtask

    // deep fill under the widest cap, then a small cap drops the backlog
    task automatic test_cap_shrink();
        wait_idle();
        idle_on <= 1'b0;
        write_reg(REG_MAX_FRAMES, 32'h0000_FFFF);
        write_reg(REG_RATE_STEP, 32'h6000_0000);
        write_reg(REG_SAMPLE_FMT, 32'(FMT_INT24));
        send_beat(KIND_CLEAR, 16'($urandom()), 16'($urandom()));
        repeat (FILL_ITEMS) send_beat(KIND_PUSH, 16'($urandom()), 16'($urandom()));
        wait_idle();
        // shrinking the cap drops all but two before the new frame goes in
        write_reg(REG_MAX_FRAMES, 32'd3);
        send_beat(KIND_PUSH, pick_sample(), pick_sample());
        repeat (2) send_beat(KIND_PULL, 16'($urandom()), 16'($urandom()));
        wait_idle();
        idle_on <= 1'b1;
    endtask

    // sequence of tests
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_flow();
        test_formats();
        test_overflow();
        test_phase_saturation();
        test_backpressure();
        test_random_phases();
        test_cap_shrink();
        wait_idle();
        if (err_count == 0 && pending_out.size() == 0) begin
            $display("stereo_fifo_linear_resampler regression: pass");
        end else begin
            $display("stereo_fifo_linear_resampler regression: fail");
        end
        $finish;
    end

endmodule
